@@ src/aarm_pkg.sv @@
// Package for the axis-angle rotation matrix block: payload structs,
// fixed-point constants and the CORDIC arctangent table. No dependencies.
package aarm_pkg;

   localparam int FracBits    = 14;
   localparam int CordicSteps = 16;
   localparam int AxisW       = 16;
   localparam int AngleW      = 16;
   localparam int OutW        = 20;
   localparam int CordW       = 34;
   localparam int ZW          = 33;
   localparam int StepIdxW    = 5;
   localparam int TrigW       = 18;
   localparam int ProdW       = 34;
   localparam int TripW       = 52;

   localparam logic signed [CordW-1:0] InvGain = CordW'(64'sh26DD3B6A);
   localparam logic signed [OutW-1:0]  OutMax  = OutW'(524287);
   localparam logic signed [OutW-1:0]  OutMin  = OutW'(-524288);

   typedef struct packed {
      logic signed [AxisW-1:0] axis_x;
      logic signed [AxisW-1:0] axis_y;
      logic signed [AxisW-1:0] axis_z;
      logic [AngleW-1:0]       angle_turns;
   } req_type;

   typedef struct packed {
      logic signed [OutW-1:0] col0_x;
      logic signed [OutW-1:0] col0_y;
      logic signed [OutW-1:0] col0_z;
      logic signed [OutW-1:0] col1_x;
      logic signed [OutW-1:0] col1_y;
      logic signed [OutW-1:0] col1_z;
      logic signed [OutW-1:0] col2_x;
      logic signed [OutW-1:0] col2_y;
      logic signed [OutW-1:0] col2_z;
   } rsp_type;

   function automatic logic signed [ZW-1:0] atan_tab(input logic [StepIdxW-1:0] i);
      logic [31:0] v;
      case (i)
         5'd0: v = 32'h20000000;   5'd1: v = 32'h12E4051E;
         5'd2: v = 32'h09FB385B;   5'd3: v = 32'h051111D4;
         5'd4: v = 32'h028B0D43;   5'd5: v = 32'h0145D7E1;
         5'd6: v = 32'h00A2F61E;   5'd7: v = 32'h00517C55;
         5'd8: v = 32'h0028BE53;   5'd9: v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;  default: v = 32'h00000000;
      endcase
      return $signed({1'b0, v});
   endfunction

endpackage

@@ src/axis_angle_rotation_matrix.sv @@
// Throughput: one request per cycle; busy is tied low, the CORDIC is
// unrolled into one register stage per iteration followed by a multiplier chain.
// Reset clears the valid bits of every stage; payload registers are not reset.
// Results cannot be stalled, so no backpressure logic exists.
// Uses aarm_pkg for payload structs, constants and the arctangent table.
module axis_angle_rotation_matrix (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  aarm_pkg::req_type  req_data,
   output logic               rsp_valid,
   output aarm_pkg::rsp_type  rsp_data
);

   localparam int N  = aarm_pkg::CordicSteps;
   localparam int CW = aarm_pkg::CordW;
   localparam int ZW = aarm_pkg::ZW;
   localparam int F  = aarm_pkg::FracBits;
   localparam int TW = aarm_pkg::TrigW;
   localparam int PW = aarm_pkg::ProdW;
   localparam int XW = aarm_pkg::TripW;
   localparam int AW = aarm_pkg::AxisW;
   localparam int OW = aarm_pkg::OutW;

   assign busy = 1'b0;

   // CORDIC stage registers, index i holds the state after i iterations
   logic                 vld_ff  [N+1];
   logic signed [CW-1:0] x_ff    [N+1];
   logic signed [CW-1:0] y_ff    [N+1];
   logic signed [ZW-1:0] z_ff    [N+1];
   logic [1:0]           quad_ff [N+1];
   logic signed [AW-1:0] ax_ff [N+1];
   logic signed [AW-1:0] ay_ff [N+1];
   logic signed [AW-1:0] az_ff [N+1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else       vld_ff[0] <= start;
      x_ff[0]    <= aarm_pkg::InvGain;
      y_ff[0]    <= '0;
      z_ff[0]    <= ZW'({req_data.angle_turns[13:0], 16'h0000});
      quad_ff[0] <= req_data.angle_turns[15:14];
      ax_ff[0]   <= req_data.axis_x;
      ay_ff[0]   <= req_data.axis_y;
      az_ff[0]   <= req_data.axis_z;
   end

   for (genvar i = 0; i < N; i++) begin : g_cordic
      logic signed [CW-1:0] dx, dy;
      logic signed [ZW-1:0] at;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign at = (i < 32) ? aarm_pkg::atan_tab(aarm_pkg::StepIdxW'(i)) : '0;
      always_ff @(posedge clock) begin
         if (reset) vld_ff[i+1] <= 1'b0;
         else       vld_ff[i+1] <= vld_ff[i];
         if (!z_ff[i][ZW-1]) begin
            x_ff[i+1] <= x_ff[i] - dx;
            y_ff[i+1] <= y_ff[i] + dy;
            z_ff[i+1] <= z_ff[i] - at;
         end else begin
            x_ff[i+1] <= x_ff[i] + dx;
            y_ff[i+1] <= y_ff[i] - dy;
            z_ff[i+1] <= z_ff[i] + at;
         end
         quad_ff[i+1] <= quad_ff[i];
         ax_ff[i+1]   <= ax_ff[i];
         ay_ff[i+1]   <= ay_ff[i];
         az_ff[i+1]   <= az_ff[i];
      end
   end

   // Stage A: quadrant fold and rounding to FracBits
   logic signed [CW-1:0] cq, sq;
   always_comb begin
      case (quad_ff[N])
         2'd0:    begin cq = x_ff[N];  sq = y_ff[N];  end
         2'd1:    begin cq = -y_ff[N]; sq = x_ff[N];  end
         2'd2:    begin cq = -x_ff[N]; sq = -y_ff[N]; end
         default: begin cq = y_ff[N];  sq = -x_ff[N]; end
      endcase
   end
   localparam int RS = 30 - F;
   logic signed [CW-1:0] cr, sr;
   assign cr = (cq + (CW'(1) <<< (RS-1))) >>> RS;
   assign sr = (sq + (CW'(1) <<< (RS-1))) >>> RS;

   logic                 a_vld_ff;
   logic signed [TW-1:0] c_a_ff, s_a_ff, u_a_ff;
   logic signed [AW-1:0] ax_a_ff, ay_a_ff, az_a_ff;
   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else       a_vld_ff <= vld_ff[N];
      c_a_ff  <= TW'(cr);
      s_a_ff  <= TW'(sr);
      u_a_ff  <= TW'((CW'(1) <<< F) - cr);
      ax_a_ff <= ax_ff[N];
      ay_a_ff <= ay_ff[N];
      az_a_ff <= az_ff[N];
   end

   // Stage B: axis products and axis times sine
   // index: 0 xx, 1 xy, 2 xz, 3 yy, 4 yz, 5 zz
   logic                 b_vld_ff;
   logic signed [PW-1:0] pp_b_ff [6];
   logic signed [PW-1:0] xs_b_ff, ys_b_ff, zs_b_ff;
   logic signed [TW-1:0] c_b_ff, u_b_ff;
   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else       b_vld_ff <= a_vld_ff;
      pp_b_ff[0] <= PW'(ax_a_ff) * PW'(ax_a_ff);
      pp_b_ff[1] <= PW'(ax_a_ff) * PW'(ay_a_ff);
      pp_b_ff[2] <= PW'(ax_a_ff) * PW'(az_a_ff);
      pp_b_ff[3] <= PW'(ay_a_ff) * PW'(ay_a_ff);
      pp_b_ff[4] <= PW'(ay_a_ff) * PW'(az_a_ff);
      pp_b_ff[5] <= PW'(az_a_ff) * PW'(az_a_ff);
      xs_b_ff <= PW'(PW'(ax_a_ff) * PW'(s_a_ff));
      ys_b_ff <= PW'(PW'(ay_a_ff) * PW'(s_a_ff));
      zs_b_ff <= PW'(PW'(az_a_ff) * PW'(s_a_ff));
      c_b_ff  <= c_a_ff;
      u_b_ff  <= u_a_ff;
   end

   // Stage C: times u, round the sine terms
   logic                 c_vld_ff;
   logic signed [XW-1:0] tp_c_ff [6];
   logic signed [PW-1:0] xs_c_ff, ys_c_ff, zs_c_ff;
   logic signed [TW-1:0] c_c_ff;
   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else       c_vld_ff <= b_vld_ff;
      for (int k = 0; k < 6; k++)
         tp_c_ff[k] <= XW'(XW'(pp_b_ff[k]) * XW'(u_b_ff));
      xs_c_ff <= (xs_b_ff + (PW'(1) <<< (F-1))) >>> F;
      ys_c_ff <= (ys_b_ff + (PW'(1) <<< (F-1))) >>> F;
      zs_c_ff <= (zs_b_ff + (PW'(1) <<< (F-1))) >>> F;
      c_c_ff  <= c_b_ff;
   end

   // Stage D: round, combine, saturate
   function automatic logic signed [OW-1:0] sat(input logic signed [XW-1:0] v);
      if (v > XW'(aarm_pkg::OutMax))      return aarm_pkg::OutMax;
      else if (v < XW'(aarm_pkg::OutMin)) return aarm_pkg::OutMin;
      else                                return OW'(v);
   endfunction

   logic signed [XW-1:0] r [6];
   logic signed [XW-1:0] cx, xs, ys, zs;
   always_comb begin
      for (int k = 0; k < 6; k++)
         r[k] = (tp_c_ff[k] + (XW'(1) <<< (2*F-1))) >>> (2*F);
      cx = XW'(c_c_ff);
      xs = XW'(xs_c_ff);
      ys = XW'(ys_c_ff);
      zs = XW'(zs_c_ff);
   end

   logic    rsp_valid_ff;
   aarm_pkg::rsp_type rsp_data_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= c_vld_ff;
      rsp_data_ff.col0_x <= sat(r[0] + cx);
      rsp_data_ff.col0_y <= sat(r[1] + zs);
      rsp_data_ff.col0_z <= sat(r[2] - ys);
      rsp_data_ff.col1_x <= sat(r[1] - zs);
      rsp_data_ff.col1_y <= sat(r[3] + cx);
      rsp_data_ff.col1_z <= sat(r[4] + xs);
      rsp_data_ff.col2_x <= sat(r[2] + ys);
      rsp_data_ff.col2_y <= sat(r[4] - xs);
      rsp_data_ff.col2_z <= sat(r[5] + cx);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_busy_low: assert property (@(posedge clock) busy == 1'b0)
      else $error("busy asserted");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      a_vld_ff |-> ##3 rsp_valid)
      else $error("result lost in multiply stages");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !c_vld_ff |=> !rsp_valid)
      else $error("result without request");
   a_valid_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(rsp_valid))
      else $error("rsp_valid unknown");
`endif

endmodule

@@ sim/axis_angle_rotation_matrix_check.sv @@
// Checker for the axis-angle rotation matrix block: watches accepted requests,
// predicts each matrix and compares it with the next result. Uses aarm_pkg.
module axis_angle_rotation_matrix_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  aarm_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  aarm_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);

   aarm_pkg::rsp_type matrix_queue[$];
   int errors = 0;

   assign pending    = matrix_queue.size();
   assign fail_count = errors;

   function automatic longint floor_sh(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_sh(longint v, int s);
      if (s == 0) return v;
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic logic [aarm_pkg::OutW-1:0] clamp_out(longint v);
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
      return v[aarm_pkg::OutW-1:0];
   endfunction

   function automatic longint atan_val(int i);
      longint t[32] = '{
         64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
         64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
         64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
         64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
         64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
         64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
         64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
         64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000};
      return t[i];
   endfunction

   function automatic aarm_pkg::rsp_type rotation_matrix(aarm_pkg::req_type r);
      aarm_pkg::rsp_type m;
      logic [31:0] a;
      longint x, y, z, dx, dy, cq, sq, c, s, u, vx, vy, vz;
      int f;
      int f2;
      f = aarm_pkg::FracBits;
      f2 = 2 * aarm_pkg::FracBits;
      a = {r.angle_turns, 16'h0000};
      z = a[29:0];
      x = 64'h26DD3B6A;
      y = 0;
      for (int i = 0; i < aarm_pkg::CordicSteps && i < 32; i++) begin
         dx = floor_sh(y, i);
         dy = floor_sh(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_val(i);
         end else begin
            x += dx; y -= dy; z += atan_val(i);
         end
      end
      case (a[31:30])
         2'd0: begin cq = x;  sq = y;  end
         2'd1: begin cq = -y; sq = x;  end
         2'd2: begin cq = -x; sq = -y; end
         default: begin cq = y; sq = -x; end
      endcase
      c = round_sh(cq, 30 - f);
      s = round_sh(sq, 30 - f);
      u = (64'sd1 <<< f) - c;
      vx = r.axis_x;
      vy = r.axis_y;
      vz = r.axis_z;
      m.col0_x = clamp_out(round_sh(vx * vx * u, f2) + c);
      m.col0_y = clamp_out(round_sh(vx * vy * u, f2) + round_sh(vz * s, f));
      m.col0_z = clamp_out(round_sh(vx * vz * u, f2) - round_sh(vy * s, f));
      m.col1_x = clamp_out(round_sh(vy * vx * u, f2) - round_sh(vz * s, f));
      m.col1_y = clamp_out(round_sh(vy * vy * u, f2) + c);
      m.col1_z = clamp_out(round_sh(vy * vz * u, f2) + round_sh(vx * s, f));
      m.col2_x = clamp_out(round_sh(vz * vx * u, f2) + round_sh(vy * s, f));
      m.col2_y = clamp_out(round_sh(vz * vy * u, f2) - round_sh(vx * s, f));
      m.col2_z = clamp_out(round_sh(vz * vz * u, f2) + c);
      return m;
   endfunction

   task automatic report_mismatch(string what, logic [aarm_pkg::OutW-1:0] got,
                                  logic [aarm_pkg::OutW-1:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic check_field(string what, logic [aarm_pkg::OutW-1:0] got,
                              logic [aarm_pkg::OutW-1:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      aarm_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (matrix_queue.size() == 0) begin
               report_mismatch("unexpected result", '0, '0);
            end else begin
               want = matrix_queue.pop_front();
               check_field("col0_x", rsp_data.col0_x, want.col0_x);
               check_field("col0_y", rsp_data.col0_y, want.col0_y);
               check_field("col0_z", rsp_data.col0_z, want.col0_z);
               check_field("col1_x", rsp_data.col1_x, want.col1_x);
               check_field("col1_y", rsp_data.col1_y, want.col1_y);
               check_field("col1_z", rsp_data.col1_z, want.col1_z);
               check_field("col2_x", rsp_data.col2_x, want.col2_x);
               check_field("col2_y", rsp_data.col2_y, want.col2_y);
               check_field("col2_z", rsp_data.col2_z, want.col2_z);
            end
         end
         if (start && !busy) matrix_queue.push_back(rotation_matrix(req_data));
      end
   end
endmodule

@@ sim/axis_angle_rotation_matrix_test.sv @@
// Testbench top for the axis-angle rotation matrix block: drives requests with
// random gaps and gives the verdict. Uses aarm_pkg and the checker module.
module axis_angle_rotation_matrix_test;

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   logic    rsp_valid;
   aarm_pkg::req_type req_data = '0;
   aarm_pkg::rsp_type rsp_data;
   int      fail_count;
   int      pending;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   axis_angle_rotation_matrix i_dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data
   );

   axis_angle_rotation_matrix_check i_check (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .fail_count, .pending
   );

   // Present one request and hold it until accepted; keep start high after.
   task automatic send_request(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               logic [15:0] ang);
      req_data <= '{axis_x: ax, axis_y: ay, axis_z: az, angle_turns: ang};
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_burst();
      start <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(int'($urandom_range(0, 32768)) - 16384);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] corners[6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000, 16'hFFFF};
      logic [15:0] angles[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                 16'hFFFF, 16'h2000, 16'h3FFF, 16'h0001};
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int i = 0; i < 6; i++)
         send_request(corners[i], corners[(i + 1) % 6], corners[(i + 3) % 6], angles[i]);
      send_request(16'h4000, 16'h0000, 16'h0000, 16'h2000);
      send_request(16'h0000, 16'h4000, 16'h0000, 16'h6000);
      send_request(16'h0000, 16'h0000, 16'h4000, 16'hA000);
      for (int i = 0; i < 8; i++)
         send_request(16'h2D41, 16'hD2BF, 16'h2D41, angles[i]);
      send_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
      send_request(16'h8000, 16'h8000, 16'h8000, 16'h4000);
      // Drain the pipe completely once before the random part.
      start <= 0;
      while (pending != 0) @(posedge clock);
      for (int n = 0; n < 1850; n++) begin
         if (n < 1500 && $urandom_range(0, 5) == 0) idle_burst();
         send_request(rand_axis(), rand_axis(), rand_axis(), 16'($urandom));
      end
      start <= 0;
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
